// ----- rtl/core/nlm_pkg.sv -----
// Shared types, constants and helpers for the nearest line matcher.
// Used by every module under rtl/core; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package nlm_pkg;

  localparam int FREQ_W    = 40;
  localparam int IDX_W     = 10;
  localparam int MAX_LINES = 1 << IDX_W;
  localparam int CNT_W     = IDX_W + 1;
  localparam int TOL_W     = 31;
  localparam int VEL_W     = 32;
  localparam int WHOLE_W   = 3;
  localparam int C_W       = 29;
  localparam int NUM_DIV_CELLS = C_W;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam logic [C_W-1:0]   LIGHT_SPEED_MS = C_W'(299792458);
  localparam logic [CNT_W-1:0] LINE_LIMIT     = CNT_W'(MAX_LINES);
  localparam logic [VEL_W-1:0] VEL_SAT_MAG    = 32'h8000_0000;
  localparam logic [VEL_W-1:0] VEL_MAX_POS    = 32'h7FFF_FFFF;
  localparam logic [TOL_W-1:0] TOL_RESET      = TOL_W'(10000);

  // Item function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Register index, taken from paddr[2]
  localparam logic REG_LINE_COUNT = 1'b0;
  localparam logic REG_VEL_TOL    = 1'b1;

  typedef struct packed {
    logic             func;
    logic [IDX_W-1:0] entry_index;
    logic [FREQ_W-1:0] freq_khz;
  } line_req_t;

  typedef struct packed {
    logic              has_match;
    logic [IDX_W-1:0]  nearest_index;
    logic [FREQ_W-1:0] nearest_freq_khz;
    logic [FREQ_W-1:0] freq_diff_khz;
    logic signed [VEL_W-1:0] delta_vel;
    logic              within_tolerance;
  } line_rsp_t;

  // Best candidate found by the table scan
  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [FREQ_W-1:0] line;
    logic [FREQ_W-1:0] diff;
  } scan_res_t;

  // Token handed from one division cell to the next
  typedef struct packed {
    logic              valid;
    logic [FREQ_W-1:0] rem;
    logic [C_W-1:0]    quo;
  } div_tok_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_DONE
  } top_state_t;

  typedef enum logic [2:0] {
    DV_IDLE,
    DV_RANGE,
    DV_WHOLE,
    DV_LAUNCH,
    DV_CHAIN,
    DV_SUM
  } div_state_t;

  // Integer part of the quotient times the speed of light (part < 8)
  function automatic logic [VEL_W-1:0] whole_times_c(input logic [WHOLE_W-1:0] w);
    logic [VEL_W-1:0] prod;
    prod = VEL_W'(w) * VEL_W'(LIGHT_SPEED_MS);
    return prod;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/nlm_div_cell.sv -----
// One step of the scaled long division: folds one bit of the speed of
// light into the running remainder and quotient. Depends on nlm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nlm_div_cell
  import nlm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              c_bit,
  input  wire logic [FREQ_W-1:0] den,
  input  wire logic [FREQ_W-1:0] rest,
  input  wire div_tok_t          tok_i,
  output div_tok_t               tok_o
);

  logic [FREQ_W+1:0] sum;
  logic [FREQ_W+1:0] den1;
  logic [FREQ_W+1:0] den2;
  logic [FREQ_W+1:0] red;
  logic [1:0]        k;

  // sum = 2*rem + bit*rest stays below 3*den, so at most two subtractions
  always_comb begin
    den1 = {2'b00, den};
    den2 = {1'b0, den, 1'b0};
    sum  = {1'b0, tok_i.rem, 1'b0} + (c_bit ? {2'b00, rest} : '0);
    if (sum >= den2) begin
      k   = 2'd2;
      red = sum - den2;
    end else if (sum >= den1) begin
      k   = 2'd1;
      red = sum - den1;
    end else begin
      k   = 2'd0;
      red = sum;
    end
  end

  always_ff @(posedge clk) begin
    tok_o.rem <= red[FREQ_W-1:0];
    tok_o.quo <= {tok_i.quo[C_W-2:0], 1'b0} + C_W'(k);
    if (rst) begin
      tok_o.valid <= 1'b0;
    end else begin
      tok_o.valid <= tok_i.valid;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/nlm_divider.sv -----
// Computes floor(num * c / den), saturated at 2^31, for den != 0.
// Integer part by compare-subtract steps, fraction through a chain of
// nlm_div_cell; depends on nlm_pkg and nlm_div_cell.
`timescale 1ns / 1ps
`default_nettype none

module nlm_divider
  import nlm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [FREQ_W-1:0] num_in,
  input  wire logic [FREQ_W-1:0] den_in,
  output logic                   done,
  output logic [VEL_W-1:0]       quo
);

  div_state_t state, state_next;

  logic [FREQ_W-1:0]  num;
  logic [FREQ_W-1:0]  den;
  logic [WHOLE_W-1:0] whole;
  logic [1:0]         step;
  logic [C_W-1:0]     frac;

  logic               over;
  logic [FREQ_W+2:0]  den_sh;
  logic               take;
  logic               launch;
  logic [VEL_W-1:0]   total;

  div_tok_t tok [NUM_DIV_CELLS+1];

  always_comb begin
    over   = {3'b000, num} >= {den, 3'b000};
    den_sh = {3'b000, den} << step;
    take   = {3'b000, num} >= den_sh;
    total  = whole_times_c(whole) + VEL_W'(frac);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      DV_IDLE:   if (start) state_next = DV_RANGE;
      DV_RANGE:  state_next = over ? DV_IDLE : DV_WHOLE;
      DV_WHOLE:  if (step == 2'd0) state_next = DV_LAUNCH;
      DV_LAUNCH: state_next = DV_CHAIN;
      DV_CHAIN:  if (tok[NUM_DIV_CELLS].valid) state_next = DV_SUM;
      DV_SUM:    state_next = DV_IDLE;
      default:   state_next = DV_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    launch = (state == DV_LAUNCH);
  end

  assign tok[0].valid = launch;
  assign tok[0].rem   = '0;
  assign tok[0].quo   = '0;

  for (genvar i = 0; i < NUM_DIV_CELLS; i++) begin : g_cell
    nlm_div_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .c_bit (LIGHT_SPEED_MS[NUM_DIV_CELLS-1-i]),
      .den   (den),
      .rest  (num),
      .tok_i (tok[i]),
      .tok_o (tok[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= ((state == DV_RANGE) && over) || (state == DV_SUM);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      DV_IDLE: begin
        if (start) begin
          num <= num_in;
          den <= den_in;
        end
      end
      DV_RANGE: begin
        whole <= '0;
        step  <= 2'd2;
        if (over) quo <= VEL_SAT_MAG;
      end
      DV_WHOLE: begin
        // num stays below 8*den here, so the remainder fits the line width
        if (take) begin
          num         <= num - den_sh[FREQ_W-1:0];
          whole[step] <= 1'b1;
        end
        step <= step - 2'd1;
      end
      DV_LAUNCH: begin
      end
      DV_CHAIN: begin
        if (tok[NUM_DIV_CELLS].valid) frac <= tok[NUM_DIV_CELLS].quo;
      end
      DV_SUM: begin
        quo <= (total > VEL_SAT_MAG) ? VEL_SAT_MAG : total;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/nlm_scan.sv -----
// Reference line table and the nearest-entry scan over it.
// One table read per cycle; depends on nlm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nlm_scan
  import nlm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  wire logic [IDX_W-1:0]  wr_addr,
  input  wire logic [FREQ_W-1:0] wr_data,
  input  wire logic              start,
  input  wire logic [CNT_W-1:0]  count,
  input  wire logic [FREQ_W-1:0] query,
  output logic                   done,
  output scan_res_t              best
);

  logic [FREQ_W-1:0] line_mem [MAX_LINES];
  logic [FREQ_W-1:0] rd_data;

  logic              busy;
  logic [IDX_W-1:0]  addr;
  logic [IDX_W-1:0]  last_idx;
  logic              issue_last;

  logic              s1_valid;
  logic [IDX_W-1:0]  s1_idx;
  logic              s1_first;
  logic              s1_last;

  logic              s2_valid;
  logic [IDX_W-1:0]  s2_idx;
  logic              s2_first;
  logic              s2_last;
  logic [FREQ_W-1:0] s2_line;
  logic [FREQ_W-1:0] s2_diff;

  logic [FREQ_W-1:0] diff;

  assign issue_last = busy && (addr == last_idx);
  assign diff = (rd_data >= query) ? (rd_data - query) : (query - rd_data);

  always_ff @(posedge clk) begin
    if (wr_en) line_mem[wr_addr] <= wr_data;
    rd_data <= line_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
      end else if (issue_last) begin
        busy <= 1'b0;
      end
      s1_valid <= busy;
      s2_valid <= s1_valid;
      done     <= s2_valid && s2_last;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      addr     <= '0;
      last_idx <= IDX_W'(count - CNT_W'(1));
    end else if (busy) begin
      addr <= addr + IDX_W'(1);
    end
    s1_idx   <= addr;
    s1_first <= (addr == '0);
    s1_last  <= issue_last;
    s2_idx   <= s1_idx;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_line  <= rd_data;
    s2_diff  <= diff;
    // strict less-than keeps the lowest index on a tie
    if (s2_valid && (s2_first || (s2_diff < best.diff))) begin
      best.idx  <= s2_idx;
      best.line <= s2_line;
      best.diff <= s2_diff;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/nearest_line_match.sv -----
// Top level of the nearest reference line matcher: APB registers, control
// and result register. Depends on nlm_pkg, nlm_scan and nlm_divider.
//
// Usage:
//   req channel (req_valid/req_ready/req_data): func = FUNC_WRITE stores
//   freq_khz at entry_index of the line table and yields no transaction on
//   rsp; func = FUNC_QUERY searches the first line_count entries.
//   rsp channel (rsp_valid/rsp_ready/rsp_data): one transaction per query.
//   APB port: line_count at byte address 0, vel_tolerance at address 4.
// Sequencing:
//   A write is stored on acceptance and leaves req_ready high. A query runs
//   n table reads (n is line_count clamped to the table depth), the scan
//   pipeline, a 3-step integer part, a 29-cell division chain and handoff.
//   req_ready stays low until the result is loaded into the rsp register, so
//   the next transaction waits for it. A zero nearest line skips the division,
//   a ratio of 8 or more ends it early; an empty table answers without a scan.
// Reset: clears control state, line_count to 0 and vel_tolerance to 10000;
//   the table contents are undefined until written.
// Stall: a finished result waits in the rsp register; the next transaction
//   is accepted meanwhile, and a second result holds until the first drains.
`timescale 1ns / 1ps
`default_nettype none

module nearest_line_match
  import nlm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,

  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire line_req_t         req_data,

  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  output line_rsp_t              rsp_data,

  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  top_state_t state, state_next;

  // Configuration registers
  logic [CNT_W-1:0]  line_count;
  logic [TOL_W-1:0]  vel_tolerance;
  logic              cfg_wr;

  // Query context
  logic [FREQ_W-1:0] query_freq;
  logic              empty;
  logic              neg;
  logic [VEL_W-1:0]  mag;

  logic              req_acc;
  logic              is_query;
  logic [CNT_W-1:0]  n_lines;
  logic              tbl_wr;
  logic              scan_start;
  logic              scan_done;
  scan_res_t         best;
  logic              div_start;
  logic              div_done;
  logic [VEL_W-1:0]  div_quo;
  logic              rsp_load;
  line_rsp_t         rsp_next;

  // APB: always ready, register chosen by paddr[2]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      REG_LINE_COUNT: prdata = APB_DW'(line_count);
      REG_VEL_TOL:    prdata = APB_DW'(vel_tolerance);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count    <= '0;
      vel_tolerance <= TOL_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_LINE_COUNT: line_count    <= pwdata[CNT_W-1:0];
        REG_VEL_TOL:    vel_tolerance <= pwdata[TOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Clamp the count to the table depth
  assign n_lines  = (line_count > LINE_LIMIT) ? LINE_LIMIT : line_count;
  assign req_acc  = req_valid && req_ready;
  assign is_query = (req_data.func == FUNC_QUERY);
  assign rsp_load = !rsp_valid || rsp_ready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_acc && is_query) begin
          state_next = (n_lines == '0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          // a zero line saturates without dividing
          state_next = (best.line == '0) ? ST_DONE : ST_DIV;
        end
      end
      ST_DIV:  if (div_done) state_next = ST_DONE;
      ST_DONE: if (rsp_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    req_ready  = (state == ST_IDLE);
    tbl_wr     = (state == ST_IDLE) && req_acc && !is_query;
    scan_start = (state == ST_IDLE) && req_acc && is_query && (n_lines != '0);
    div_start  = (state == ST_SCAN) && scan_done && (best.line != '0);
  end

  // Assemble the result from the held best entry and velocity magnitude
  always_comb begin
    rsp_next = '0;
    if (!empty) begin
      rsp_next.has_match        = 1'b1;
      rsp_next.nearest_index    = best.idx;
      rsp_next.nearest_freq_khz = best.line;
      rsp_next.freq_diff_khz    = best.diff;
      rsp_next.delta_vel        = neg ? (VEL_W'(0) - mag) : mag;
      rsp_next.within_tolerance = (mag <= VEL_W'(vel_tolerance));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == ST_DONE) && rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    // Capture the query
    if ((state == ST_IDLE) && req_acc && is_query) begin
      query_freq <= req_data.freq_khz;
      empty      <= (n_lines == '0);
    end
    // Sign and zero-line saturation once the nearest line is known
    if ((state == ST_SCAN) && scan_done) begin
      if (best.line == '0) begin
        neg <= 1'b1;
        mag <= VEL_SAT_MAG;
      end else begin
        neg <= (best.line < query_freq);
      end
    end
    // Clamp the positive side to the largest signed value
    if ((state == ST_DIV) && div_done) begin
      mag <= (!neg && (div_quo > VEL_MAX_POS)) ? VEL_MAX_POS : div_quo;
    end
    if ((state == ST_DONE) && rsp_load) begin
      rsp_data <= rsp_next;
    end
  end

  nlm_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (tbl_wr),
    .wr_addr (req_data.entry_index),
    .wr_data (req_data.freq_khz),
    .start   (scan_start),
    .count   (n_lines),
    .query   (query_freq),
    .done    (scan_done),
    .best    (best)
  );

  nlm_divider u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num_in (best.diff),
    .den_in (best.line),
    .done   (div_done),
    .quo    (div_quo)
  );

endmodule

`default_nettype wire
